// ===== rtl/rpu_pkg.sv =====
`timescale 1ns / 1ps

package rpu_pkg;

  localparam int IDX_W    = 10;
  localparam int DATA_W   = 32;
  localparam int STEP_W   = 31;
  localparam int ETA_W    = 16;
  localparam int ETA_FRAC = 14;
  localparam int SIGN_W   = 2;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REGSEL_W = PADDR_W - 2;

  localparam int PROD_W   = STEP_W + ETA_W;
  localparam int SCALED_W = PROD_W - ETA_FRAC;

  localparam logic [STEP_W-1:0] STEP_ALL_ONES = {STEP_W{1'b1}};

  typedef enum logic [1:0] {
    CASE_SAME  = 2'd0,
    CASE_BACK  = 2'd1,
    CASE_FRESH = 2'd2,
    CASE_LOAD  = 2'd3
  } upd_case_t;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'd0;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd3;

  localparam logic [REGSEL_W-1:0] REG_ETA_MINUS    = 3'd0;
  localparam logic [REGSEL_W-1:0] REG_ETA_PLUS     = 3'd1;
  localparam logic [REGSEL_W-1:0] REG_STEP_MIN     = 3'd2;
  localparam logic [REGSEL_W-1:0] REG_STEP_MAX     = 3'd3;
  localparam logic [REGSEL_W-1:0] REG_STEP_INITIAL = 3'd4;

  localparam logic [ETA_W-1:0]  ETA_MINUS_RST    = 16'd8192;
  localparam logic [ETA_W-1:0]  ETA_PLUS_RST     = 16'd19661;
  localparam logic [STEP_W-1:0] STEP_MIN_RST     = 31'd1;
  localparam logic [STEP_W-1:0] STEP_MAX_RST     = 31'd3276800;
  localparam logic [STEP_W-1:0] STEP_INITIAL_RST = 31'd6554;

  // one table entry, kept as a single memory word
  typedef struct packed {
    logic [DATA_W-1:0] weight;
    logic [STEP_W-1:0] step;
    logic [DATA_W-1:0] last_delta;
    logic [SIGN_W-1:0] sign;
  } wrec_t;

  localparam int REC_W = $bits(wrec_t);

  function automatic logic [SIGN_W-1:0] sign_of(input logic [DATA_W-1:0] v);
    logic [SIGN_W-1:0] s;
    priority if (v[DATA_W-1]) begin
      s = SIGN_NEG;
    end else if (v != '0) begin
      s = SIGN_POS;
    end else begin
      s = SIGN_ZERO;
    end
    return s;
  endfunction

endpackage

// ===== rtl/rpu_ram.sv =====
`timescale 1ns / 1ps

module rpu_ram #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and write to the same address return the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rprop_plus_weight_update.sv =====
// channel | handshake                    | payload
// --------+------------------------------+-----------------------------------------
// in      | in_valid / in_ready          | op, weight_index, value
// out     | out_valid / out_ready        | weight_index_res, new_weight, update_case
// config  | psel, penable, pwrite/pready | paddr, pwdata, prdata
//
// One item per cycle through a three-stage read-modify-write on a single table RAM
// (read, scale step, write back), unless held by out_ready low or a same-entry stall;
// an item on the same entry as the item directly ahead of it waits in stage 1 for
// that write-back, then takes the word from the write-back register.
// Reset clears control and loads config defaults; table entries are undefined until loaded, no clearing pass.
// With out_ready low the result is held and up to two further items are taken.
`timescale 1ns / 1ps

module rprop_plus_weight_update #(
  parameter int NUM_WEIGHTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [rpu_pkg::IDX_W-1:0]           weight_index,
  input  logic signed [rpu_pkg::DATA_W-1:0]   value,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rpu_pkg::IDX_W-1:0]           weight_index_res,
  output logic signed [rpu_pkg::DATA_W-1:0]   new_weight,
  output rpu_pkg::upd_case_t                  update_case,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rpu_pkg::PADDR_W-1:0]         paddr,
  input  logic [rpu_pkg::PDATA_W-1:0]         pwdata,
  output logic [rpu_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  import rpu_pkg::*;

  localparam int AW = $clog2(NUM_WEIGHTS);

  // index modulo NUM_WEIGHTS by shifted conditional subtraction
  function automatic logic [IDX_W-1:0] wrap_index(input logic [IDX_W-1:0] x);
    logic [31:0] r;
    r = 32'(x);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (r >= (32'(NUM_WEIGHTS) << k)) begin
        r = r - (32'(NUM_WEIGHTS) << k);
      end
    end
    return r[IDX_W-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [ETA_W-1:0]    eta_minus;
  logic [ETA_W-1:0]    eta_plus;
  logic [STEP_W-1:0]   step_min;
  logic [STEP_W-1:0]   step_max;
  logic [STEP_W-1:0]   step_initial;
  logic [REGSEL_W-1:0] reg_sel;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      eta_minus    <= ETA_MINUS_RST;
      eta_plus     <= ETA_PLUS_RST;
      step_min     <= STEP_MIN_RST;
      step_max     <= STEP_MAX_RST;
      step_initial <= STEP_INITIAL_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ETA_MINUS:    eta_minus    <= pwdata[ETA_W-1:0];
        REG_ETA_PLUS:     eta_plus     <= pwdata[ETA_W-1:0];
        REG_STEP_MIN:     step_min     <= pwdata[STEP_W-1:0];
        REG_STEP_MAX:     step_max     <= pwdata[STEP_W-1:0];
        REG_STEP_INITIAL: step_initial <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ETA_MINUS:    prdata = PDATA_W'(eta_minus);
      REG_ETA_PLUS:     prdata = PDATA_W'(eta_plus);
      REG_STEP_MIN:     prdata = PDATA_W'(step_min);
      REG_STEP_MAX:     prdata = PDATA_W'(step_max);
      REG_STEP_INITIAL: prdata = PDATA_W'(step_initial);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- pipeline control
  logic              in_acc;
  logic [IDX_W-1:0]  idx_in;

  logic              p1_valid;
  logic              p1_op;
  logic [IDX_W-1:0]  p1_idx;
  logic [DATA_W-1:0] p1_value;
  logic              p1_adv;

  logic              p2_valid;
  upd_case_t         p2_case;
  logic [IDX_W-1:0]  p2_idx;
  logic [DATA_W-1:0] p2_value;
  logic [SIGN_W-1:0] p2_gsign;
  wrec_t             p2_rec;
  logic [PROD_W-1:0] p2_prod;
  logic              p2_adv;
  logic              p2_free;

  logic              wb_valid;
  logic [IDX_W-1:0]  wb_idx;
  wrec_t             wb_rec;

  logic              hazard;
  logic              fwd;

  assign in_acc  = in_valid && in_ready;
  assign idx_in  = wrap_index(weight_index);

  assign p2_adv  = p2_valid && (!out_valid || out_ready);
  assign p2_free = !p2_valid || p2_adv;
  // entry still being written by the stage ahead: hold stage 1 until it is written back
  assign hazard  = p2_valid && (p2_idx == p1_idx);
  assign p1_adv  = p1_valid && !hazard && p2_free;
  assign in_ready = !p1_valid || p1_adv;

  // ---------------------------------------------------------------- table RAM
  logic [REC_W-1:0] ram_rdata;
  wrec_t            new_rec;

  rpu_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_WEIGHTS)
  ) u_table (
    .clk   (clk),
    .we    (p2_adv),
    .waddr (AW'(p2_idx)),
    .wdata (new_rec),
    .re    (in_acc),
    .raddr (AW'(idx_in)),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- stage 1: read
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (in_ready) begin
      p1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_op    <= op;
      p1_idx   <= idx_in;
      p1_value <= value;
    end
  end

  wrec_t             cur;
  logic [SIGN_W-1:0] gsign;
  logic              pnz;
  logic              gnz;
  upd_case_t         p1_case;
  logic [ETA_W-1:0]  eta_sel;
  logic [PROD_W-1:0] p1_prod;

  // the write-back register always holds the latest write, so a match wins
  assign fwd   = wb_valid && (wb_idx == p1_idx);
  assign cur   = fwd ? wb_rec : wrec_t'(ram_rdata);
  assign gsign = sign_of(p1_value);
  assign pnz   = (cur.sign != SIGN_ZERO);
  assign gnz   = (gsign != SIGN_ZERO);

  always_comb begin
    priority if (p1_op == OP_LOAD) begin
      p1_case = CASE_LOAD;
    end else if (pnz && gnz && (cur.sign != gsign)) begin
      p1_case = CASE_BACK;
    end else if (pnz && gnz) begin
      p1_case = CASE_SAME;
    end else begin
      p1_case = CASE_FRESH;
    end
  end

  assign eta_sel = (p1_case == CASE_BACK) ? eta_minus : eta_plus;
  assign p1_prod = PROD_W'(cur.step) * PROD_W'(eta_sel);

  // ---------------------------------------------------------------- stage 2: modify, write
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (p2_free) begin
      p2_valid <= p1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      p2_case  <= p1_case;
      p2_idx   <= p1_idx;
      p2_value <= p1_value;
      p2_gsign <= gsign;
      p2_rec   <= cur;
      p2_prod  <= p1_prod;
    end
  end

  logic [SCALED_W-1:0] scaled;
  logic [STEP_W-1:0]   step_shrunk;
  logic [STEP_W-1:0]   step_back;
  logic [STEP_W-1:0]   step_same;
  logic [STEP_W-1:0]   step_mv;
  logic [DATA_W:0]     step_ext;
  logic [DATA_W:0]     delta;
  logic [DATA_W:0]     w_ext;
  logic [DATA_W:0]     ld_ext;
  logic [DATA_W:0]     wsum;
  logic [DATA_W-1:0]   w_sat;

  assign scaled      = p2_prod[PROD_W-1:ETA_FRAC];
  assign step_shrunk = (scaled > SCALED_W'(STEP_ALL_ONES)) ? STEP_ALL_ONES
                                                           : scaled[STEP_W-1:0];
  assign step_back   = (step_shrunk < step_min) ? step_min : step_shrunk;
  assign step_same   = (scaled > SCALED_W'(step_max)) ? step_max : scaled[STEP_W-1:0];
  assign step_mv     = (p2_case == CASE_SAME) ? step_same : p2_rec.step;

  assign step_ext = (DATA_W + 1)'(step_mv);
  always_comb begin
    unique case (p2_gsign)
      SIGN_POS: delta = -step_ext;
      SIGN_NEG: delta = step_ext;
      default:  delta = '0;
    endcase
  end

  assign w_ext  = {p2_rec.weight[DATA_W-1], p2_rec.weight};
  assign ld_ext = {p2_rec.last_delta[DATA_W-1], p2_rec.last_delta};
  assign wsum   = (p2_case == CASE_BACK) ? (w_ext - ld_ext) : (w_ext + delta);
  // overflow when the two top bits differ
  assign w_sat  = (wsum[DATA_W] != wsum[DATA_W-1])
                ? {wsum[DATA_W], {(DATA_W - 1){~wsum[DATA_W]}}}
                : wsum[DATA_W-1:0];

  always_comb begin
    unique case (p2_case)
      CASE_LOAD: begin
        new_rec.weight     = p2_value;
        new_rec.step       = step_initial;
        new_rec.last_delta = '0;
        new_rec.sign       = SIGN_ZERO;
      end
      CASE_BACK: begin
        new_rec.weight     = w_sat;
        new_rec.step       = step_back;
        new_rec.last_delta = p2_rec.last_delta;
        new_rec.sign       = SIGN_ZERO;
      end
      CASE_SAME: begin
        new_rec.weight     = w_sat;
        new_rec.step       = step_same;
        new_rec.last_delta = delta[DATA_W-1:0];
        new_rec.sign       = p2_gsign;
      end
      CASE_FRESH: begin
        new_rec.weight     = w_sat;
        new_rec.step       = p2_rec.step;
        new_rec.last_delta = delta[DATA_W-1:0];
        new_rec.sign       = p2_gsign;
      end
    endcase
  end

  // ---------------------------------------------------------------- write-back copy, output
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (p2_adv) begin
      wb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_adv) begin
      wb_idx <= p2_idx;
      wb_rec <= new_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p2_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_adv) begin
      weight_index_res <= p2_idx;
      new_weight       <= new_rec.weight;
      update_case      <= p2_case;
    end
  end

`ifndef SYNTH
  a_out_matches_wb: assert property (@(posedge clk) disable iff (rst)
    p2_adv |=> (out_valid && weight_index_res == wb_idx && new_weight == wb_rec.weight))
    else $error("result transfer disagrees with written entry");

  a_load_init: assert property (@(posedge clk) disable iff (rst)
    (p2_adv && p2_case == CASE_LOAD) |=>
      (update_case == CASE_LOAD && new_weight == $past(p2_value) &&
       wb_rec.step == $past(step_initial) && wb_rec.sign == SIGN_ZERO))
    else $error("load did not initialise entry");

  a_back_keeps_delta: assert property (@(posedge clk) disable iff (rst)
    (p2_adv && p2_case == CASE_BACK) |=>
      (wb_rec.sign == SIGN_ZERO && wb_rec.last_delta == $past(p2_rec.last_delta)))
    else $error("backtrack altered last delta or kept sign");

  a_hazard_forwards: assert property (@(posedge clk) disable iff (rst)
    (p1_valid && hazard && p2_adv) |=> (p1_valid && fwd))
    else $error("same-entry item did not pick up write-back");

  a_step_cap: assert property (@(posedge clk) disable iff (rst)
    (p2_adv && p2_case == CASE_SAME) |=> (wb_rec.step <= $past(step_max)))
    else $error("grown step exceeds step_max");
`endif

endmodule
